### design/rrq_pkg.sv
// Shared constants, types and ring-address helpers for the booking queue.
package rrq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_BITS    = 16;

  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int KEY_W   = (KEY_BITS < 16) ? KEY_BITS : 16;
  localparam int MIN_W   = 16;
  localparam int ENTRY_W = KEY_W + MIN_W;

  typedef enum logic [1:0] {
    OP_BOOK    = 2'd0,
    OP_CANCEL  = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_LIST    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } ring_req_t;

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] logical);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(logical);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] head);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(1);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = '0;
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### design/round_robin_queue_with_cancel_top.sv
// Round-robin booking queue with cancel by key: sequencer, counters and output register.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid in_ready operation user_key           | to block
//           | booked_minutes                                 |
//   out     | out_valid out_ready status entry_key           | from block
//           | entry_minutes entry_count last_result          |
//
// One ring access per step: book writes the entry unless full, then reads the head;
// advance reads the head, writes it at the tail, reads the new head; list reads each
// entry; cancel searches, shifts later entries down. Others skip to the result if empty.
// Reset empties the queue and puts the head at slot 0; ring contents stay undefined.
// in_ready is high only between items; a result waiting in the output register does
// not block the next item, but a new result waits until that register is taken.
module round_robin_queue_with_cancel_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] user_key,
  input  logic [15:0] booked_minutes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] entry_key,
  output logic [15:0] entry_minutes,
  output logic [6:0]  entry_count,
  output logic        last_result
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_HEAD_RD   = 11'b000_0000_0010,
    S_EMIT      = 11'b000_0000_0100,
    S_SRCH_RD   = 11'b000_0000_1000,
    S_SRCH_CMP  = 11'b000_0001_0000,
    S_SHIFT_RD  = 11'b000_0010_0000,
    S_SHIFT_WR  = 11'b000_0100_0000,
    S_ADV_RD    = 11'b000_1000_0000,
    S_ADV_WR    = 11'b001_0000_0000,
    S_LIST_RD   = 11'b010_0000_0000,
    S_LIST_EMIT = 11'b100_0000_0000
  } state_t;

  state_t                      state, state_next;
  logic [rrq_pkg::CNT_W-1:0]   count, count_next;
  logic [rrq_pkg::IDX_W-1:0]   head, head_next;
  logic [rrq_pkg::CNT_W-1:0]   idx, idx_next;
  logic [rrq_pkg::KEY_W-1:0]   key, key_next;
  rrq_pkg::status_t            stat, stat_next;
  logic                        have, have_next;

  rrq_pkg::ring_req_t          req;
  logic [rrq_pkg::ENTRY_W-1:0] rdata;
  logic [rrq_pkg::KEY_W-1:0]   rd_key;
  logic [rrq_pkg::MIN_W-1:0]   rd_min;

  logic                        accept;
  logic                        load;
  logic                        load_last;
  logic [rrq_pkg::CNT_W:0]     idx_p1;
  logic [rrq_pkg::CNT_W:0]     idx_p2;
  logic [rrq_pkg::CNT_W:0]     cnt_w;
  logic                        full;

  rrq_ring u_ring (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign rd_key   = rdata[rrq_pkg::ENTRY_W-1 -: rrq_pkg::KEY_W];
  assign rd_min   = rdata[rrq_pkg::MIN_W-1:0];
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_p1   = (rrq_pkg::CNT_W+1)'(idx) + (rrq_pkg::CNT_W+1)'(1);
  assign idx_p2   = (rrq_pkg::CNT_W+1)'(idx) + (rrq_pkg::CNT_W+1)'(2);
  assign cnt_w    = (rrq_pkg::CNT_W+1)'(count);
  assign full     = (count == rrq_pkg::CNT_W'(rrq_pkg::QUEUE_DEPTH));
  assign load     = ((state == S_EMIT) || (state == S_LIST_EMIT)) && (!out_valid || out_ready);
  assign load_last = (state == S_EMIT) || (idx_p1 == cnt_w);

  always_comb begin
    state_next = state;
    count_next = count;
    head_next  = head;
    idx_next   = idx;
    key_next   = key;
    stat_next  = stat;
    have_next  = have;
    req        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          key_next  = user_key[rrq_pkg::KEY_W-1:0];
          idx_next  = '0;
          stat_next = rrq_pkg::ST_OK;
          have_next = 1'b1;
          unique case (rrq_pkg::op_t'(operation))
            rrq_pkg::OP_BOOK: begin
              if (full) begin
                stat_next = rrq_pkg::ST_FULL;
              end else begin
                req.we     = 1'b1;
                req.waddr  = rrq_pkg::slot_of(head, count);
                req.wdata  = {user_key[rrq_pkg::KEY_W-1:0], booked_minutes};
                count_next = count + rrq_pkg::CNT_W'(1);
              end
              state_next = S_HEAD_RD;
            end
            rrq_pkg::OP_CANCEL, rrq_pkg::OP_ADVANCE, rrq_pkg::OP_LIST: begin
              if (count == '0) begin
                stat_next  = rrq_pkg::ST_EMPTY;
                have_next  = 1'b0;
                state_next = S_EMIT;
              end else if (rrq_pkg::op_t'(operation) == rrq_pkg::OP_CANCEL) begin
                state_next = S_SRCH_RD;
              end else if (rrq_pkg::op_t'(operation) == rrq_pkg::OP_ADVANCE) begin
                state_next = S_ADV_RD;
              end else begin
                state_next = S_LIST_RD;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_HEAD_RD: begin
        req.re     = 1'b1;
        req.raddr  = head;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      S_SRCH_RD: begin
        req.re     = 1'b1;
        req.raddr  = rrq_pkg::slot_of(head, idx);
        state_next = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        priority if (rd_key == key) begin
          if (idx_p1 < cnt_w) begin
            state_next = S_SHIFT_RD;
          end else begin
            count_next = count - rrq_pkg::CNT_W'(1);
            if (count == rrq_pkg::CNT_W'(1)) begin
              head_next  = '0;
              have_next  = 1'b0;
              state_next = S_EMIT;
            end else begin
              state_next = S_HEAD_RD;
            end
          end
        end else if (idx_p1 == cnt_w) begin
          stat_next  = rrq_pkg::ST_NOT_FOUND;
          state_next = S_HEAD_RD;
        end else begin
          idx_next   = idx_p1[rrq_pkg::CNT_W-1:0];
          state_next = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        req.re     = 1'b1;
        req.raddr  = rrq_pkg::slot_of(head, idx_p1[rrq_pkg::CNT_W-1:0]);
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        req.we   = 1'b1;
        req.waddr = rrq_pkg::slot_of(head, idx);
        req.wdata = rdata;
        idx_next = idx_p1[rrq_pkg::CNT_W-1:0];
        if (idx_p2 < cnt_w) begin
          state_next = S_SHIFT_RD;
        end else begin
          count_next = count - rrq_pkg::CNT_W'(1);
          state_next = S_HEAD_RD;
        end
      end
      S_ADV_RD: begin
        req.re     = 1'b1;
        req.raddr  = head;
        state_next = S_ADV_WR;
      end
      S_ADV_WR: begin
        req.we     = 1'b1;
        req.waddr  = rrq_pkg::slot_of(head, count);
        req.wdata  = rdata;
        head_next  = rrq_pkg::next_slot(head);
        state_next = S_HEAD_RD;
      end
      S_LIST_RD: begin
        req.re     = 1'b1;
        req.raddr  = rrq_pkg::slot_of(head, idx);
        state_next = S_LIST_EMIT;
      end
      S_LIST_EMIT: begin
        if (load) begin
          if (load_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx_p1[rrq_pkg::CNT_W-1:0];
            state_next = S_LIST_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      head  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
    end
    idx  <= idx_next;
    key  <= key_next;
    stat <= stat_next;
    have <= have_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status        <= (state == S_EMIT) ? stat : rrq_pkg::ST_OK;
      entry_key     <= have ? 16'(rd_key) : 16'd0;
      entry_minutes <= have ? rd_min : 16'd0;
      entry_count   <= 7'(count);
      last_result   <= load_last;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= rrq_pkg::CNT_W'(rrq_pkg::QUEUE_DEPTH))
    else $error("held count above queue depth");

  a_empty_head : assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == '0)
    else $error("empty queue with head away from slot zero");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + rrq_pkg::CNT_W'(1)
                     || count == $past(count) - rrq_pkg::CNT_W'(1)))
    else $error("held count moved by more than one");

  a_empty_result : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rrq_pkg::ST_EMPTY |-> entry_key == 16'd0 && entry_count == 7'd0
                                                  && last_result)
    else $error("empty-queue result carries an entry");

endmodule

### design/rrq_ring.sv
// Booking ring storage: one write port, one registered read port.
module rrq_ring (
  input  logic                          clk,
  input  rrq_pkg::ring_req_t            req,
  output logic [rrq_pkg::ENTRY_W-1:0]   rdata
);

  logic [rrq_pkg::ENTRY_W-1:0] mem [rrq_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
